### src/cdbe_pkg.sv
package cdbe_pkg;

    localparam logic [2:0] OP_LINE   = 3'd0;
    localparam logic [2:0] OP_SQUARE = 3'd1;
    localparam logic [2:0] OP_SHADE  = 3'd2;
    localparam logic [2:0] OP_COPY   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_360 = 9'd360;

    localparam logic [2:0] SHADE_WHITE = 3'd4;
    localparam logic [2:0] SHADE_MAX   = 3'd4;

    // Directions in steps of 45 degrees, with the row and column step of each.
    localparam logic [8:0] DIR_ANGLE [8] = '{9'd0, 9'd45, 9'd90, 9'd135,
                                            9'd180, 9'd225, 9'd270, 9'd315};
    localparam logic [1:0] STEP_ROW [8] = '{2'b11, 2'b11, 2'b00, 2'b01,
                                           2'b01, 2'b01, 2'b00, 2'b11};
    localparam logic [1:0] STEP_COL [8] = '{2'b00, 2'b01, 2'b01, 2'b01,
                                           2'b00, 2'b11, 2'b11, 2'b11};

    typedef struct packed {
        logic [2:0]        opcode;
        logic [5:0]        org_row;
        logic [6:0]        org_col;
        logic signed [7:0] length;
        logic [8:0]        direction;
        logic [5:0]        dst_row;
        logic [6:0]        dst_col;
        logic signed [3:0] shade_change;
    } t_cmd;

    typedef struct packed {
        logic       status;
        logic [2:0] pixel_value;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DISPATCH,
        ST_DRAW,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_READ_RD,
        ST_READ_DATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic decode;
        logic clr_wr;
        logic draw_wr;
        logic copy_wr;
        logic step;
        logic cap_pix;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       ok;
        logic [2:0] op;
        logic       len_zero;
        logic       walk_last;
        logic       out_free;
    } t_dp_status;

endpackage

### src/cdbe_stream_if.sv
interface cdbe_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/canvas_draw_and_blit_engine.sv
// Channel | Dir | Payload | Beat taken when
// i_cmd   | in  | t_cmd   | i_cmd.valid && i_cmd.ready
// o_rsp   | out | t_rsp   | o_rsp.valid && o_rsp.ready
//
// After reset the canvas is swept to white, one pixel a cycle, over all
// CANVAS_ROWS*CANVAS_COLS pixels; no command is taken during the sweep.
// After decode and dispatch, a command draws its pixels one by one or copies
// each as a read then a write (on the one canvas memory port pair); a pixel
// read issues the read and then captures the data. The largest shape is a
// square with the shorter canvas edge as side, 32 by 32 on the default canvas.
// A response waits in an output register; the next command is taken meanwhile.
module canvas_draw_and_blit_engine import cdbe_pkg::*; #(
    parameter int CANVAS_ROWS = 32,
    parameter int CANVAS_COLS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cdbe_stream_if.sink   i_cmd,
    cdbe_stream_if.source o_rsp
);
    localparam int DEPTH = CANVAS_ROWS * CANVAS_COLS;
    localparam int AW    = $clog2(DEPTH);

    t_dp_cmd       cmd;
    t_dp_status    status;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [2:0]    wdata, rdata;
    logic          in_ready;

    cdbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_cmd.ready = in_ready;

    cdbe_datapath #(
        .CANVAS_ROWS (CANVAS_ROWS),
        .CANVAS_COLS (CANVAS_COLS),
        .AW          (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_data  (i_cmd.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_out_data  (o_rsp.data)
    );

    cdbe_ram #(
        .WIDTH (3),
        .DEPTH (DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );
endmodule

### src/cdbe_ram.sv
module cdbe_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

### src/cdbe_ctrl.sv
module cdbe_ctrl import cdbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                priority if (!i_status.ok)             n_state = ST_DONE;
                else if (i_status.op == OP_SHADE)      n_state = ST_DONE;
                else if (i_status.op == OP_READ)       n_state = ST_READ_RD;
                else if (i_status.len_zero)            n_state = ST_DONE;
                else if (i_status.op == OP_COPY)       n_state = ST_COPY_RD;
                else                                   n_state = ST_DRAW;
            end
            ST_DRAW: begin
                if (i_status.walk_last) n_state = ST_DONE;
            end
            ST_COPY_RD: n_state = ST_COPY_WR;
            ST_COPY_WR: begin
                n_state = i_status.walk_last ? ST_DONE : ST_COPY_RD;
            end
            ST_READ_RD:   n_state = ST_READ_DATA;
            ST_READ_DATA: n_state = ST_DONE;
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_wr = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: o_cmd.decode = 1'b1;
            ST_DRAW: begin
                o_cmd.draw_wr = 1'b1;
                o_cmd.step    = 1'b1;
            end
            ST_COPY_WR: begin
                o_cmd.copy_wr = 1'b1;
                o_cmd.step    = 1'b1;
            end
            ST_READ_DATA: o_cmd.cap_pix = 1'b1;
            ST_DONE: o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end
endmodule

### src/cdbe_datapath.sv
module cdbe_datapath import cdbe_pkg::*; #(
    parameter int CANVAS_ROWS = 32,
    parameter int CANVAS_COLS = 64,
    parameter int AW          = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd_data,
    input  t_dp_cmd       i_cmd,
    output t_dp_status    o_status,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [2:0]    o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [2:0]    i_rdata,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_rsp          o_out_data
);
    localparam int           DEPTH    = CANVAS_ROWS * CANVAS_COLS;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    t_cmd          r_c;
    logic [AW-1:0] r_clr;
    logic [2:0]    r_shade;
    logic          r_ok;
    logic [7:0]    r_lm1;
    logic          r_len_zero;
    logic          r_square;
    logic [1:0]    r_dr, r_dc;
    logic [7:0]    r_a, r_b;
    logic [7:0]    r_trow, r_tcol, r_srow, r_scol, r_tcol0, r_scol0;
    logic [2:0]    r_pix;
    logic          r_out_valid;
    t_rsp          r_out;

    logic [8:0]        d0, d1;
    logic              neg;
    logic [7:0]        mag;
    logic              hit;
    logic [2:0]        k;
    logic [1:0]        dr, dc;
    logic              ok;
    logic signed [4:0] shade_sum;
    logic              last;

    function automatic logic fits(input logic [6:0] r, input logic [6:0] c,
                                  input logic [7:0] m, input logic [1:0] sr,
                                  input logic [1:0] sc);
        logic signed [9:0] off, fr, fc;
        logic              on0, on1;
        off = $signed({2'b00, m}) - 10'sd1;
        fr  = $signed({3'b000, r}) + ((sr == 2'b01) ? off :
                                      (sr == 2'b11) ? -off : 10'sd0);
        fc  = $signed({3'b000, c}) + ((sc == 2'b01) ? off :
                                      (sc == 2'b11) ? -off : 10'sd0);
        on0 = ({3'b000, r} < 10'(CANVAS_ROWS)) && ({3'b000, c} < 10'(CANVAS_COLS));
        on1 = (fr >= 10'sd0) && (fr < $signed(10'(CANVAS_ROWS)))
              && (fc >= 10'sd0) && (fc < $signed(10'(CANVAS_COLS)));
        return on0 && ((m == 8'd0) || on1);
    endfunction

    function automatic logic [AW-1:0] addr(input logic [7:0] r, input logic [7:0] c);
        return AW'(AW'(r[6:0]) * AW'(CANVAS_COLS) + AW'(c[6:0]));
    endfunction

    // Direction decode: fold into 0..359, turn round for a negative length.
    always_comb begin
        d0  = (r_c.direction >= DEG_360) ? r_c.direction - DEG_360 : r_c.direction;
        neg = r_c.length[7];
        mag = neg ? 8'(-r_c.length) : r_c.length;
        if (!neg) begin
            d1 = d0;
        end else begin
            d1 = (d0 >= DEG_180) ? d0 - DEG_180 : d0 + DEG_180;
        end
        hit = 1'b0;
        k   = '0;
        for (int i = 0; i < 8; i++) begin
            if (d1 == DIR_ANGLE[i]) begin
                hit = 1'b1;
                k   = 3'(i);
            end
        end
        dr = STEP_ROW[k];
        dc = STEP_COL[k];
        priority if (r_c.opcode == OP_SHADE) begin
            ok = 1'b1;
        end else if (r_c.opcode == OP_READ) begin
            ok = fits({1'b0, r_c.org_row}, r_c.org_col, 8'd0, 2'b00, 2'b00);
        end else if (r_c.opcode > OP_READ) begin
            ok = 1'b0;
        end else begin
            ok = hit && fits({1'b0, r_c.org_row}, r_c.org_col, mag, dr, dc)
                 && ((r_c.opcode != OP_COPY)
                     || fits({1'b0, r_c.dst_row}, r_c.dst_col, mag, dr, dc));
        end
        shade_sum = $signed({2'b00, r_shade}) + 5'(r_c.shade_change);
    end

    assign last = (r_a == r_lm1) && (!r_square || r_b == r_lm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_shade     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);
            if (i_cmd.decode && r_c.opcode == OP_SHADE && shade_sum >= 5'sd0
                && shade_sum <= $signed({2'b00, SHADE_MAX})) begin
                r_shade <= shade_sum[2:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_c <= i_cmd_data;
        if (i_cmd.decode) begin
            r_ok       <= ok;
            r_lm1      <= mag - 8'd1;
            r_len_zero <= (mag == 8'd0);
            r_square   <= k[0] && (r_c.opcode != OP_LINE);
            r_dr       <= dr;
            r_dc       <= dc;
            r_a        <= '0;
            r_b        <= '0;
            r_srow     <= {2'b00, r_c.org_row};
            r_scol     <= {1'b0, r_c.org_col};
            r_scol0    <= {1'b0, r_c.org_col};
            r_pix      <= '0;
            if (r_c.opcode == OP_COPY) begin
                r_trow  <= {2'b00, r_c.dst_row};
                r_tcol  <= {1'b0, r_c.dst_col};
                r_tcol0 <= {1'b0, r_c.dst_col};
            end else begin
                r_trow  <= {2'b00, r_c.org_row};
                r_tcol  <= {1'b0, r_c.org_col};
                r_tcol0 <= {1'b0, r_c.org_col};
            end
        end
        if (i_cmd.step) begin
            if (r_square && r_b != r_lm1) begin
                r_b    <= r_b + 8'd1;
                r_tcol <= r_tcol + {{6{r_dc[1]}}, r_dc};
                r_scol <= r_scol + {{6{r_dc[1]}}, r_dc};
            end else begin
                r_b    <= '0;
                r_a    <= r_a + 8'd1;
                r_trow <= r_trow + {{6{r_dr[1]}}, r_dr};
                r_srow <= r_srow + {{6{r_dr[1]}}, r_dr};
                if (r_square) begin
                    r_tcol <= r_tcol0;
                    r_scol <= r_scol0;
                end else begin
                    r_tcol <= r_tcol + {{6{r_dc[1]}}, r_dc};
                    r_scol <= r_scol + {{6{r_dc[1]}}, r_dc};
                end
            end
        end
        if (i_cmd.cap_pix) r_pix <= i_rdata;
        if (i_cmd.out_load) begin
            r_out.status      <= !r_ok;
            r_out.pixel_value <= r_pix;
        end
    end

    always_comb begin
        o_we    = i_cmd.clr_wr || i_cmd.draw_wr || i_cmd.copy_wr;
        o_waddr = i_cmd.clr_wr ? r_clr : addr(r_trow, r_tcol);
        priority if (i_cmd.clr_wr) o_wdata = SHADE_WHITE;
        else if (i_cmd.copy_wr)    o_wdata = i_rdata;
        else                       o_wdata = r_shade;
    end

    assign o_raddr = addr(r_srow, r_scol);

    assign o_status.clr_last  = (r_clr == CLR_LAST);
    assign o_status.ok        = r_ok;
    assign o_status.op        = r_c.opcode;
    assign o_status.len_zero  = r_len_zero;
    assign o_status.walk_last = last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

### src/cdbe_checker.sv
module cdbe_checker import cdbe_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cmd_valid,
    input logic i_cmd_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);
    // No response can be pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled response changed");

    // A rejected command never carries a pixel, and shades stay within range.
    a_pixel_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.pixel_value <= SHADE_MAX)
                        && (!i_rsp_data.status || i_rsp_data.pixel_value == 3'd0))
        else $error("bad pixel in response");

    // A command is decoded before the next one can be taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command taken while busy");
endmodule

bind canvas_draw_and_blit_engine cdbe_checker u_cdbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
